[design/qpd_pkg.sv]
// Shared types, character codes and hex helpers for the quoted-printable decoder.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package qpd_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_EQ    = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_SKIP  = 2'd3
  } qpd_mode_e;

  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_F   = 8'h46;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;  // 'A' - 10

  // Result bundle for one input byte: cnt is the number of valid bytes (0 to 3),
  // byte 0 goes out first.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } qpd_res_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_0) && (c <= CH_9)) begin
      v = c - CH_0;
    end else begin
      v = c - HEX_ALPHA_OFS;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

[design/qpd_decode.sv]
// Decode state machine: mode and held hex digit, plus the result bundle for one byte.
// Depends on qpd_pkg.
`default_nettype none

module qpd_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       byte_i,
  input  wire logic             eod_i,
  input  wire logic             advance_i,
  output qpd_pkg::qpd_res_t     res_o
);

  qpd_pkg::qpd_mode_e mode_q, mode_d;
  logic [7:0]         held_q, held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qpd_pkg::MODE_PLAIN;
      held_q <= 8'h00;
    end else if (advance_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    held_d       = held_q;
    res_o.cnt    = 2'd0;
    res_o.bytes  = '0;
    unique case (mode_q)
      qpd_pkg::MODE_PLAIN: begin
        if (byte_i == qpd_pkg::CH_EQ) begin
          mode_d = qpd_pkg::MODE_EQ;
        end else begin
          res_o.cnt      = 2'd1;
          res_o.bytes[0] = byte_i;
        end
      end
      qpd_pkg::MODE_EQ: begin
        if (byte_i == qpd_pkg::CH_LF) begin
          mode_d = qpd_pkg::MODE_PLAIN;
        end else if ((byte_i == qpd_pkg::CH_CR) || (byte_i == qpd_pkg::CH_SP) ||
                     (byte_i == qpd_pkg::CH_TAB)) begin
          mode_d = qpd_pkg::MODE_SKIP;
        end else if (qpd_pkg::is_hex(byte_i) && !eod_i) begin
          held_d = byte_i;
          mode_d = qpd_pkg::MODE_HEX1;
        end else begin
          // invalid escape, or a single digit at end of data: pass raw
          res_o.cnt      = 2'd2;
          res_o.bytes[0] = qpd_pkg::CH_EQ;
          res_o.bytes[1] = byte_i;
          mode_d         = qpd_pkg::MODE_PLAIN;
        end
      end
      qpd_pkg::MODE_HEX1: begin
        if (qpd_pkg::is_hex(byte_i)) begin
          res_o.cnt      = 2'd1;
          res_o.bytes[0] = {qpd_pkg::hex_value(held_q), qpd_pkg::hex_value(byte_i)};
        end else begin
          res_o.cnt      = 2'd3;
          res_o.bytes[0] = qpd_pkg::CH_EQ;
          res_o.bytes[1] = held_q;
          res_o.bytes[2] = byte_i;
        end
        held_d = 8'h00;
        mode_d = qpd_pkg::MODE_PLAIN;
      end
      qpd_pkg::MODE_SKIP: begin
        if (byte_i == qpd_pkg::CH_LF) begin
          mode_d = qpd_pkg::MODE_PLAIN;
        end
      end
      default: begin
        mode_d = qpd_pkg::MODE_PLAIN;
      end
    endcase
    // end of data starts a fresh message
    if (eod_i) begin
      mode_d = qpd_pkg::MODE_PLAIN;
      held_d = 8'h00;
    end
  end

endmodule

`default_nettype wire

[design/qpd_out_buf.sv]
// Result register: holds one bundle of up to three bytes and emits them one per cycle while out_ready_i is high.
// Depends on qpd_pkg.
`default_nettype none

module qpd_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire qpd_pkg::qpd_res_t res_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o
);

  logic            vld_q, vld_d;
  logic [1:0]      cnt_q;
  logic [1:0]      idx_q, idx_d;
  logic [2:0][7:0] bytes_q;
  logic            is_last;
  logic            pop;

  assign is_last     = (idx_q == (cnt_q - 2'd1));
  assign pop         = vld_q && out_ready_i;
  assign can_load_o  = !vld_q || (pop && is_last);
  assign out_valid_o = vld_q;
  assign out_byte_o  = bytes_q[idx_q];
  assign run_last_o  = is_last;

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = 2'd0;
    end else if (pop) begin
      if (is_last) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
      cnt_q <= 2'd1;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
      if (load_i) begin
        cnt_q <= res_i.cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (cnt_q != 2'd0))
    else $error("result buffer valid with empty bundle");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (idx_q < cnt_q))
    else $error("result index beyond bundle");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> (vld_q && $stable(idx_q)))
    else $error("stalled result lost or advanced");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (can_load_o && (res_i.cnt != 2'd0)))
    else $error("bundle loaded over pending results");

endmodule

`default_nettype wire

[design/quoted_printable_decoder.sv]
// Top level of the quoted-printable decoder: input register, decode stage, result buffer.
// Depends on qpd_pkg, qpd_decode and qpd_out_buf.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one encoded byte per transaction,
//   with end_of_data_i marking the final byte of a message. Output channel
//   (out_valid_o / out_ready_i) carries one decoded byte per transaction; run_last_o
//   flags the final byte produced by a given input byte.
//   Data path: an accepted byte lands in the input register, is decoded there and its
//   results move into the result buffer, which drives out_valid_o.
//   Throughput: one input byte per cycle while each byte yields at most one result and
//   out_ready_i stays high. The result buffer emits one byte per cycle while out_ready_i
//   is high, so a byte that yields several results (raw escapes: two or three) holds the
//   input until its last result is emitted. Bytes that yield nothing ('=', soft breaks,
//   skipped whitespace) drain from the input register without touching the buffer.
//   Reset: the decoder returns to plain text mode with no held digit, and both the
//   input register and the result buffer are empty.
//   Receiver stall: the buffer holds its current byte; the input register then holds
//   the next byte that yields results, and in_ready_o drops until space opens up.
`default_nettype none

module quoted_printable_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eod_q;

  qpd_pkg::qpd_res_t res;
  logic              can_load;
  logic              advance;
  logic              load;

  // Advance the held byte when it yields nothing, or when the buffer can take its bundle.
  assign advance    = in_vld_q && ((res.cnt == 2'd0) || can_load);
  assign load       = advance && (res.cnt != 2'd0);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Payload: capture on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_eod_q  <= end_of_data_i;
    end
  end

  qpd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .eod_i     (in_eod_q),
    .advance_i (advance),
    .res_o     (res)
  );

  qpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

`default_nettype wire

[verif/quoted_printable_decoder_tb.sv]
// Self-checking testbench for quoted_printable_decoder: directed rows, then random messages.
// Depends on qpd_pkg for character codes and the decode mode type; needs only the RTL.
`default_nettype none

module quoted_printable_decoder_tb;

  localparam int DIR_ROWS     = 24;
  localparam int RANDOM_ITEMS = 106;
  localparam int MAX_GAP      = 18;
  // No transaction on either channel for this long means the block is stuck.
  localparam int IDLE_LIMIT   = 2000;
  // Margin to wait once every expected byte is out, before the summary.
  localparam int DRAIN_CYCLES = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       end_of_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  // One decoded byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } qp_out_t;

  // One directed row: the encoded byte, and optionally the decoded bytes typed in by hand.
  typedef struct packed {
    logic [7:0] in_b;
    logic       eod;
    logic       typed;
    logic [1:0] cnt;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } qp_row_t;

  qp_out_t    pending_out_q[$];
  qp_row_t    directed_rows [DIR_ROWS];

  // Predictor copy of the decoder state.
  qpd_pkg::qpd_mode_e qp_mode;
  logic [7:0]         qp_held;

  int bytes_in;
  int bytes_out   = 0;
  int msgs_ended;
  int mismatches  = 0;
  int idle_cycles = 0;
  int tx_calm_left;
  int rx_calm_left;

  quoted_printable_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic hex_char(input logic [7:0] c);
    return (c >= qpd_pkg::CH_0 && c <= qpd_pkg::CH_9) ||
           (c >= qpd_pkg::CH_A && c <= qpd_pkg::CH_F);
  endfunction

  // Digits keep their low nibble; uppercase letters sit at 0x41..0x46, so add nine.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    return c[6] ? c[3:0] + 4'd9 : c[3:0];
  endfunction

  // Advance the decoder state by one encoded byte; return how many bytes it yields.
  function automatic int decode_step(input logic [7:0] c, input logic eod,
                                     output logic [7:0] r0, output logic [7:0] r1,
                                     output logic [7:0] r2);
    int n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    r2 = '0;
    case (qp_mode)
      qpd_pkg::MODE_PLAIN: begin
        if (c == qpd_pkg::CH_EQ) begin
          qp_mode = qpd_pkg::MODE_EQ;
        end else begin
          r0 = c;
          n  = 1;
        end
      end
      qpd_pkg::MODE_EQ: begin
        if (c == qpd_pkg::CH_LF) begin
          qp_mode = qpd_pkg::MODE_PLAIN;        // soft break, nothing out
        end else if (c == qpd_pkg::CH_CR || c == qpd_pkg::CH_SP ||
                     c == qpd_pkg::CH_TAB) begin
          qp_mode = qpd_pkg::MODE_SKIP;
        end else if (hex_char(c) && !eod) begin
          qp_held = c;
          qp_mode = qpd_pkg::MODE_HEX1;
        end else begin
          // Invalid escape, or a single digit at end of data: pass both raw.
          r0      = qpd_pkg::CH_EQ;
          r1      = c;
          n       = 2;
          qp_mode = qpd_pkg::MODE_PLAIN;
        end
      end
      qpd_pkg::MODE_HEX1: begin
        if (hex_char(c)) begin
          r0 = {nibble_of(qp_held), nibble_of(c)};
          n  = 1;
        end else begin
          r0 = qpd_pkg::CH_EQ;
          r1 = qp_held;
          r2 = c;
          n  = 3;
        end
        qp_held = '0;
        qp_mode = qpd_pkg::MODE_PLAIN;
      end
      default: begin
        if (c == qpd_pkg::CH_LF) qp_mode = qpd_pkg::MODE_PLAIN;
      end
    endcase
    if (eod) begin
      qp_mode = qpd_pkg::MODE_PLAIN;
      qp_held = '0;
    end
    return n;
  endfunction

  // Queue n decoded bytes; the last one carries run_last.
  task automatic queue_results(input int n, input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
    qp_out_t item;
    for (int k = 0; k < n; k++) begin
      item.data = (k == 0) ? b0 : (k == 1) ? b1 : b2;
      item.last = (k == n - 1);
      pending_out_q.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Hold off a random number of cycles, then present one byte until the transaction
  // completes. Valid stays high on return, so a zero gap next time keeps it up.
  task automatic drive_byte(input logic [7:0] b, input logic eod);
    int gap;
    if (tx_calm_left > 0) begin
      gap = 0;
      tx_calm_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 15) == 0) tx_calm_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_data_i <= eod;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_in++;
    if (eod) msgs_ended++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eod);
    logic [7:0] r0, r1, r2;
    int n;
    drive_byte(b, eod);
    n = decode_step(b, eod, r0, r1, r2);
    queue_results(n, r0, r1, r2);
  endtask

  function automatic logic [7:0] pick_hex();
    int k;
    k = $urandom_range(0, 15);
    return (k < 10) ? qpd_pkg::CH_0 + 8'(k) : qpd_pkg::CH_A + 8'(k - 10);
  endfunction

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 2);
    return (k == 0) ? qpd_pkg::CH_CR : (k == 1) ? qpd_pkg::CH_SP : qpd_pkg::CH_TAB;
  endfunction

  // Any byte but the one given.
  function automatic logic [7:0] pick_other(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == avoid) ? ~b : b;
  endfunction

  // Send one encoded unit: mostly well-formed pieces of a message, some broken
  // escapes, escapes cut short by end of data, and plain noise.
  task automatic send_token();
    int  kind;
    int  cut;
    logic fin;
    kind = $urandom_range(0, 99);
    fin  = ($urandom_range(0, 7) == 0);
    if (kind < 30) begin
      send_byte(pick_other(qpd_pkg::CH_EQ), fin);
    end else if (kind < 50) begin
      send_byte(qpd_pkg::CH_EQ, 1'b0);
      send_byte(pick_hex(), 1'b0);
      send_byte(pick_hex(), fin);
    end else if (kind < 58) begin
      send_byte(qpd_pkg::CH_EQ, 1'b0);
      send_byte(qpd_pkg::CH_LF, fin);
    end else if (kind < 68) begin
      // Whitespace after '=': everything up to LF is swallowed.
      send_byte(qpd_pkg::CH_EQ, 1'b0);
      send_byte(pick_space(), 1'b0);
      repeat ($urandom_range(0, 4)) send_byte(pick_other(qpd_pkg::CH_LF), 1'b0);
      send_byte(qpd_pkg::CH_LF, fin);
    end else if (kind < 76) begin
      send_byte(qpd_pkg::CH_EQ, 1'b0);
      send_byte(pick_other(qpd_pkg::CH_LF), fin);
    end else if (kind < 84) begin
      // First digit good, second one not a hex digit.
      send_byte(qpd_pkg::CH_EQ, 1'b0);
      send_byte(pick_hex(), 1'b0);
      send_byte(8'($urandom_range(8'h47, 8'hFF)), fin);
    end else if (kind < 92) begin
      // Escape cut short by end of data.
      cut = $urandom_range(0, 3);
      send_byte(qpd_pkg::CH_EQ, cut == 0);
      if (cut == 1) send_byte(pick_hex(), 1'b1);
      if (cut >= 2) send_byte(pick_space(), cut == 2);
      if (cut == 3) send_byte(pick_other(qpd_pkg::CH_LF), 1'b1);
    end else begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Draw a stall per decoded byte, with occasional stretches of no stalling.
  initial begin : receiver
    int gap;
    rx_calm_left = 0;
    forever begin
      if (rx_calm_left > 0) begin
        gap = 0;
        rx_calm_left--;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 15) == 0) rx_calm_left = $urandom_range(5, 20);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk_i) begin : out_check
    qp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_out++;
      if (pending_out_q.size() == 0) begin
        $display("%0t: unexpected output byte %02h run_last %0b", $time, out_byte_o,
                 run_last_o);
        mismatches++;
      end else begin
        want = pending_out_q.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte_o);
          mismatches++;
        end
        if (run_last_o !== want.last) begin
          $display("%0t: run_last expected %0b got %0b", $time, want.last, run_last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: reset the count on any transaction, bail out when it runs away.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d bytes still expected", $time,
               idle_cycles, pending_out_q.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [7:0] r0, r1, r2;
    int  n;
    logic paused;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_byte_i     <= '0;
    end_of_data_i <= 1'b0;
    bytes_in     = 0;
    msgs_ended   = 0;
    tx_calm_left = 0;
    paused       = 1'b0;
    qp_mode      = qpd_pkg::MODE_PLAIN;
    qp_held      = '0;

    // in_b, eod, typed, cnt, decoded bytes
    directed_rows = '{
      '{8'h00,  1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},  // extremes pass through
      '{8'hFF,  1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // =0F decodes
      '{qpd_pkg::CH_0,   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_F,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // lowercase is not hex
      '{8'h61,  1'b0, 1'b1, 2'd2, qpd_pkg::CH_EQ, 8'h61, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // soft break
      '{qpd_pkg::CH_LF,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // CR skip swallows '='
      '{qpd_pkg::CH_CR,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_LF,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // data ends during skip
      '{qpd_pkg::CH_SP,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{8'h71,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // bad second digit: 3 raw
      '{qpd_pkg::CH_9,   1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{8'h47,  1'b0, 1'b1, 2'd3, qpd_pkg::CH_EQ, qpd_pkg::CH_9,  8'h47},
      '{qpd_pkg::CH_EQ,  1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // lone '=' at end dropped
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // one digit at end: raw
      '{qpd_pkg::CH_A,   1'b1, 1'b1, 2'd2, qpd_pkg::CH_EQ, qpd_pkg::CH_A,  8'h00},
      '{qpd_pkg::CH_EQ,  1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},  // whitespace at end
      '{qpd_pkg::CH_TAB, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: typed rows use the hand-written bytes, the rest the predictor.
    for (int i = 0; i < DIR_ROWS; i++) begin
      drive_byte(directed_rows[i].in_b, directed_rows[i].eod);
      n = decode_step(directed_rows[i].in_b, directed_rows[i].eod, r0, r1, r2);
      if (directed_rows[i].typed) begin
        queue_results(directed_rows[i].cnt, directed_rows[i].e0, directed_rows[i].e1,
                      directed_rows[i].e2);
      end else begin
        queue_results(n, r0, r1, r2);
      end
    end

    // Drop valid and let the output side drain completely before going random.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_out_q.size() != 0);

    while (bytes_in < DIR_ROWS + RANDOM_ITEMS) begin
      send_token();
      // Halfway through, hold input until every expected byte is out.
      if (!paused && bytes_in >= DIR_ROWS + RANDOM_ITEMS / 2) begin
        paused     = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_out_q.size() != 0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d encoded bytes (%0d directed) in %0d ended messages",
             bytes_in, DIR_ROWS, msgs_ended);
    $display("checked %0d decoded bytes, %0d mismatches", bytes_out, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
